// File: rtl/core/i2cm_pkg.sv
// i2cm_pkg: shared types and constants for the i2c master byte engine
// no dependencies; used by i2cm_step and i2c_master_byte_engine

package i2cm_pkg;

    localparam int DELAY_W = 16;
    localparam int BYTE_W = 8;
    localparam int BIT_W = 4;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd20;
    localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        KIND_IDLE  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_READ  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'd0,
        PH_SECOND = 3'd1,
        PH_THIRD  = 3'd2,
        PH_FOURTH = 3'd3,
        PH_FIFTH  = 3'd4
    } phase_t;

    typedef struct packed {
        kind_t               kind;
        phase_t              phase;
        logic [BIT_W-1:0]    bit_index;
        logic [DELAY_W-1:0]  wait_count;
        logic [BYTE_W-1:0]   shift_byte;
        logic                ack_choice;
        logic                ack_flag;
        logic                scl_level;
        logic                sda_level;
        logic [BYTE_W-1:0]   read_result;
    } eng_state_t;

endpackage

// File: rtl/core/i2cm_step.sv
// i2cm_step: one tick of the byte sequencer, pure combinational
// depends on i2cm_pkg for the state struct and command codes

module i2cm_step (
    input  i2cm_pkg::eng_state_t          cur,
    input  logic [i2cm_pkg::DELAY_W-1:0]  delay_ticks,
    input  logic [2:0]                    mode,
    input  logic [i2cm_pkg::BYTE_W-1:0]   write_data,
    input  logic                          ack_to_send,
    input  logic                          sda_in,
    output i2cm_pkg::eng_state_t          nxt,
    output logic                          finished
);

    logic [i2cm_pkg::DELAY_W-1:0] delay_eff;
    logic                         run;

    assign delay_eff = (delay_ticks == '0) ? i2cm_pkg::DELAY_W'(1) : delay_ticks;

    always_comb
    begin
        logic [i2cm_pkg::BYTE_W-1:0] shifted;
        logic [i2cm_pkg::BIT_W-1:0]  bit_inc;

        nxt = cur;
        finished = 1'b0;
        run = 1'b0;
        shifted = '0;
        bit_inc = '0;

        if (cur.kind == i2cm_pkg::KIND_IDLE)
        begin
            if (mode inside {[i2cm_pkg::KIND_START:i2cm_pkg::KIND_READ]})
            begin
                nxt.kind = i2cm_pkg::kind_t'(mode);
                nxt.phase = i2cm_pkg::PH_FIRST;
                nxt.bit_index = '0;
                nxt.shift_byte = (mode == i2cm_pkg::KIND_WRITE) ? write_data : '0;
                nxt.ack_choice = ack_to_send;
                run = 1'b1;
            end
        end
        else
        begin
            nxt.wait_count = cur.wait_count - 1'b1;
            run = (cur.wait_count == i2cm_pkg::DELAY_W'(1));
        end

        if (run)
        begin
            shifted = {nxt.shift_byte[i2cm_pkg::BYTE_W-2:0], 1'b0};
            bit_inc = nxt.bit_index + 1'b1;
            nxt.wait_count = delay_eff;
            case (nxt.kind)
                i2cm_pkg::KIND_START:
                begin
                    case (nxt.phase)
                        i2cm_pkg::PH_FIRST:
                        begin
                            nxt.sda_level = 1'b1;
                            nxt.scl_level = 1'b1;
                            nxt.phase = i2cm_pkg::PH_SECOND;
                        end
                        i2cm_pkg::PH_SECOND:
                        begin
                            nxt.sda_level = 1'b0;
                            nxt.phase = i2cm_pkg::PH_THIRD;
                        end
                        i2cm_pkg::PH_THIRD:
                        begin
                            nxt.scl_level = 1'b0;
                            nxt.phase = i2cm_pkg::PH_FOURTH;
                        end
                        default:
                            finished = 1'b1;
                    endcase
                end
                i2cm_pkg::KIND_STOP:
                begin
                    case (nxt.phase)
                        i2cm_pkg::PH_FIRST:
                        begin
                            nxt.sda_level = 1'b0;
                            nxt.scl_level = 1'b1;
                            nxt.phase = i2cm_pkg::PH_SECOND;
                        end
                        i2cm_pkg::PH_SECOND:
                        begin
                            nxt.sda_level = 1'b1;
                            nxt.phase = i2cm_pkg::PH_THIRD;
                        end
                        default:
                            finished = 1'b1;
                    endcase
                end
                i2cm_pkg::KIND_WRITE:
                begin
                    case (nxt.phase)
                        i2cm_pkg::PH_FIRST:
                        begin
                            nxt.sda_level = nxt.shift_byte[i2cm_pkg::BYTE_W-1];
                            nxt.phase = i2cm_pkg::PH_SECOND;
                        end
                        i2cm_pkg::PH_SECOND:
                        begin
                            nxt.scl_level = 1'b1;
                            nxt.phase = i2cm_pkg::PH_THIRD;
                        end
                        i2cm_pkg::PH_THIRD:
                        begin
                            nxt.scl_level = 1'b0;
                            nxt.shift_byte = shifted;
                            nxt.bit_index = bit_inc;
                            if (bit_inc < i2cm_pkg::BITS_PER_BYTE)
                            begin
                                nxt.sda_level = shifted[i2cm_pkg::BYTE_W-1];
                                nxt.phase = i2cm_pkg::PH_SECOND;
                            end
                            else
                            begin
                                nxt.sda_level = 1'b1;
                                nxt.phase = i2cm_pkg::PH_FOURTH;
                            end
                        end
                        i2cm_pkg::PH_FOURTH:
                        begin
                            nxt.scl_level = 1'b1;
                            nxt.phase = i2cm_pkg::PH_FIFTH;
                        end
                        default:
                        begin
                            nxt.ack_flag = sda_in;
                            nxt.scl_level = 1'b0;
                            finished = 1'b1;
                        end
                    endcase
                end
                i2cm_pkg::KIND_READ:
                begin
                    case (nxt.phase)
                        i2cm_pkg::PH_FIRST:
                        begin
                            nxt.sda_level = 1'b1;
                            nxt.scl_level = 1'b1;
                            nxt.phase = i2cm_pkg::PH_SECOND;
                        end
                        i2cm_pkg::PH_SECOND:
                        begin
                            nxt.shift_byte = {nxt.shift_byte[i2cm_pkg::BYTE_W-2:0], sda_in};
                            nxt.scl_level = 1'b0;
                            nxt.phase = i2cm_pkg::PH_THIRD;
                        end
                        i2cm_pkg::PH_THIRD:
                        begin
                            nxt.bit_index = bit_inc;
                            if (bit_inc < i2cm_pkg::BITS_PER_BYTE)
                            begin
                                nxt.scl_level = 1'b1;
                                nxt.phase = i2cm_pkg::PH_SECOND;
                            end
                            else
                            begin
                                nxt.sda_level = ~nxt.ack_choice;
                                nxt.phase = i2cm_pkg::PH_FOURTH;
                            end
                        end
                        i2cm_pkg::PH_FOURTH:
                        begin
                            nxt.scl_level = 1'b1;
                            nxt.phase = i2cm_pkg::PH_FIFTH;
                        end
                        default:
                        begin
                            nxt.scl_level = 1'b0;
                            nxt.sda_level = 1'b1;
                            nxt.read_result = nxt.shift_byte;
                            finished = 1'b1;
                        end
                    endcase
                end
                default:
                    finished = 1'b1;
            endcase

            if (finished)
            begin
                nxt.kind = i2cm_pkg::KIND_IDLE;
                nxt.phase = i2cm_pkg::PH_FIRST;
                nxt.wait_count = '0;
            end
        end
    end

endmodule

// File: rtl/core/i2c_master_byte_engine.sv
// i2c_master_byte_engine: tick-driven i2c master byte sequencer, top level
// depends on i2cm_pkg and i2cm_step
//
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    mode, write_data, ack_to_send, sda_in
// out      source     out_valid / out_ready  scl_release, sda_release, busy_res,
//                                            done_res, read_data, ack_seen
// cfg      sink       cfg_valid / cfg_ready  cfg_data (delay_ticks)
//
// one beat in, one beat out; a taken beat is held in the input register, then one
// sequencer step moves it into the result register, from which the result beat is
// offered; one beat per cycle is sustained while out_ready stays high
// reset releases both lines and loads a delay of 20 ticks
// a stall on out holds the input register and backs up in_ready; cfg_ready is always high

module i2c_master_byte_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    mode,
    input  logic [i2cm_pkg::BYTE_W-1:0]   write_data,
    input  logic                          ack_to_send,
    input  logic                          sda_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          scl_release,
    output logic                          sda_release,
    output logic                          busy_res,
    output logic                          done_res,
    output logic [i2cm_pkg::BYTE_W-1:0]   read_data,
    output logic                          ack_seen,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [i2cm_pkg::DELAY_W-1:0]  cfg_data
);

    logic                          in_valid_reg;
    logic [2:0]                    mode_reg;
    logic [i2cm_pkg::BYTE_W-1:0]   write_data_reg;
    logic                          ack_to_send_reg;
    logic                          sda_in_reg;
    logic [i2cm_pkg::DELAY_W-1:0]  delay_reg;
    i2cm_pkg::eng_state_t          state_reg;
    i2cm_pkg::eng_state_t          state_next;
    logic                          finished;
    logic                          advance;
    logic                          out_valid_reg;
    logic                          done_reg;

    assign advance = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    i2cm_step u_step (
        .cur         (state_reg),
        .delay_ticks (delay_reg),
        .mode        (mode_reg),
        .write_data  (write_data_reg),
        .ack_to_send (ack_to_send_reg),
        .sda_in      (sda_in_reg),
        .nxt         (state_next),
        .finished    (finished)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            done_reg <= 1'b0;
            delay_reg <= i2cm_pkg::DELAY_RESET;
            state_reg <= '{
                kind:        i2cm_pkg::KIND_IDLE,
                phase:       i2cm_pkg::PH_FIRST,
                bit_index:   '0,
                wait_count:  '0,
                shift_byte:  '0,
                ack_choice:  1'b0,
                ack_flag:    1'b0,
                scl_level:   1'b1,
                sda_level:   1'b1,
                read_result: '0
            };
        end
        else
        begin
            if (cfg_valid)
            begin
                delay_reg <= cfg_data;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
                done_reg <= finished;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= mode;
            write_data_reg <= write_data;
            ack_to_send_reg <= ack_to_send;
            sda_in_reg <= sda_in;
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_release = state_reg.scl_level;
    assign sda_release = state_reg.sda_level;
    assign busy_res = (state_reg.kind != i2cm_pkg::KIND_IDLE);
    assign done_res = done_reg;
    assign read_data = state_reg.read_result;
    assign ack_seen = state_reg.ack_flag;

endmodule

// File: bench/i2c_master_byte_engine_tb.sv
// i2c_master_byte_engine_tb: self-checking bench for the tick-driven i2c master byte engine
// a table of directed commands, then random bus transactions, checked beat by beat
// against a line-level predictor; depends on i2cm_pkg and i2c_master_byte_engine

module i2c_master_byte_engine_tb;

    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_MID = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int DIR_ROWS = 18;
    localparam int RANDOM_TICKS = 250;
    localparam int LONG_HOLD = 40;
    localparam int STALL_LIMIT = 400;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic                        scl;
        logic                        sda;
        logic                        busy;
        logic                        done;
        logic [i2cm_pkg::BYTE_W-1:0] rbyte;
        logic                        ack;
    } line_view_t;

    typedef struct packed {
        logic                         set_cfg;
        logic [i2cm_pkg::DELAY_W-1:0] dly;
        logic [2:0]                   m;
        logic [i2cm_pkg::BYTE_W-1:0]  wd;
        logic                         a;
        logic [i2cm_pkg::BYTE_W-1:0]  sb;
        logic                         sa;
        logic                         typed;
        line_view_t                   want;
    } cmd_row_t;

    localparam line_view_t IDLE_VIEW = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
    localparam line_view_t START_VIEW = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [2:0]                   mode;
    logic [i2cm_pkg::BYTE_W-1:0]  write_data;
    logic                         ack_to_send;
    logic                         sda_in;
    logic                         out_valid;
    logic                         out_ready;
    logic                         scl_release;
    logic                         sda_release;
    logic                         busy_res;
    logic                         done_res;
    logic [i2cm_pkg::BYTE_W-1:0]  read_data;
    logic                         ack_seen;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [i2cm_pkg::DELAY_W-1:0] cfg_data;

    // predicted engine state
    i2cm_pkg::kind_t              eng_kind = i2cm_pkg::KIND_IDLE;
    i2cm_pkg::phase_t             eng_seg = i2cm_pkg::PH_FIRST;
    logic [i2cm_pkg::BIT_W-1:0]   eng_bits = '0;
    logic [i2cm_pkg::DELAY_W-1:0] eng_wait = '0;
    logic [i2cm_pkg::BYTE_W-1:0]  eng_shift = '0;
    logic                         eng_ack_out = 1'b0;
    logic                         eng_ack_in = 1'b0;
    logic                         eng_scl = 1'b1;
    logic                         eng_sda = 1'b1;
    logic [i2cm_pkg::BYTE_W-1:0]  eng_rbyte = '0;
    logic [i2cm_pkg::DELAY_W-1:0] eng_delay = i2cm_pkg::DELAY_RESET;

    line_view_t line_views_due [$];
    cmd_row_t   dir_rows [DIR_ROWS];
    int         mismatches = 0;
    int         beats_seen = 0;
    int         busy_ticks = 0;
    int         stall_cycles = 0;
    int         hold_asks = 0;
    int         holds_done = 0;
    bit         calm = 1'b0;

    i2c_master_byte_engine dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .write_data  (write_data),
        .ack_to_send (ack_to_send),
        .sda_in      (sda_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .scl_release (scl_release),
        .sda_release (sda_release),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .read_data   (read_data),
        .ack_seen    (ack_seen),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void arm_wait(input i2cm_pkg::phase_t nxt);
        eng_wait = (eng_delay == '0) ? 16'd1 : eng_delay;
        eng_seg = nxt;
    endfunction

    // one segment of the running command; returns 1 when the command is over
    function automatic logic bus_segment(input logic s);
        logic fin;
        fin = 1'b0;
        case (eng_kind)
            i2cm_pkg::KIND_START:
                case (eng_seg)
                    i2cm_pkg::PH_FIRST:
                    begin
                        eng_sda = 1'b1;
                        eng_scl = 1'b1;
                        arm_wait(i2cm_pkg::PH_SECOND);
                    end
                    i2cm_pkg::PH_SECOND:
                    begin
                        eng_sda = 1'b0;
                        arm_wait(i2cm_pkg::PH_THIRD);
                    end
                    i2cm_pkg::PH_THIRD:
                    begin
                        eng_scl = 1'b0;
                        arm_wait(i2cm_pkg::PH_FOURTH);
                    end
                    default: fin = 1'b1;
                endcase
            i2cm_pkg::KIND_STOP:
                case (eng_seg)
                    i2cm_pkg::PH_FIRST:
                    begin
                        eng_sda = 1'b0;
                        eng_scl = 1'b1;
                        arm_wait(i2cm_pkg::PH_SECOND);
                    end
                    i2cm_pkg::PH_SECOND:
                    begin
                        eng_sda = 1'b1;
                        arm_wait(i2cm_pkg::PH_THIRD);
                    end
                    default: fin = 1'b1;
                endcase
            i2cm_pkg::KIND_WRITE:
                case (eng_seg)
                    i2cm_pkg::PH_FIRST:
                    begin
                        eng_sda = eng_shift[i2cm_pkg::BYTE_W-1];
                        arm_wait(i2cm_pkg::PH_SECOND);
                    end
                    i2cm_pkg::PH_SECOND:
                    begin
                        eng_scl = 1'b1;
                        arm_wait(i2cm_pkg::PH_THIRD);
                    end
                    i2cm_pkg::PH_THIRD:
                    begin
                        eng_scl = 1'b0;
                        eng_shift = eng_shift << 1;
                        eng_bits = eng_bits + 4'd1;
                        if (eng_bits < i2cm_pkg::BITS_PER_BYTE)
                        begin
                            eng_sda = eng_shift[i2cm_pkg::BYTE_W-1];
                            arm_wait(i2cm_pkg::PH_SECOND);
                        end
                        else
                        begin
                            eng_sda = 1'b1;
                            arm_wait(i2cm_pkg::PH_FOURTH);
                        end
                    end
                    i2cm_pkg::PH_FOURTH:
                    begin
                        eng_scl = 1'b1;
                        arm_wait(i2cm_pkg::PH_FIFTH);
                    end
                    default:
                    begin
                        eng_ack_in = s;
                        eng_scl = 1'b0;
                        fin = 1'b1;
                    end
                endcase
            i2cm_pkg::KIND_READ:
                case (eng_seg)
                    i2cm_pkg::PH_FIRST:
                    begin
                        eng_sda = 1'b1;
                        eng_scl = 1'b1;
                        arm_wait(i2cm_pkg::PH_SECOND);
                    end
                    i2cm_pkg::PH_SECOND:
                    begin
                        eng_shift = {eng_shift[i2cm_pkg::BYTE_W-2:0], s};
                        eng_scl = 1'b0;
                        arm_wait(i2cm_pkg::PH_THIRD);
                    end
                    i2cm_pkg::PH_THIRD:
                    begin
                        eng_bits = eng_bits + 4'd1;
                        if (eng_bits < i2cm_pkg::BITS_PER_BYTE)
                        begin
                            eng_scl = 1'b1;
                            arm_wait(i2cm_pkg::PH_SECOND);
                        end
                        else
                        begin
                            eng_sda = ~eng_ack_out;
                            arm_wait(i2cm_pkg::PH_FOURTH);
                        end
                    end
                    i2cm_pkg::PH_FOURTH:
                    begin
                        eng_scl = 1'b1;
                        arm_wait(i2cm_pkg::PH_FIFTH);
                    end
                    default:
                    begin
                        eng_scl = 1'b0;
                        eng_sda = 1'b1;
                        eng_rbyte = eng_shift;
                        fin = 1'b1;
                    end
                endcase
            default: fin = 1'b1;
        endcase
        return fin;
    endfunction

    // advances the predicted engine by one tick and returns the bus view after it
    function automatic line_view_t advance_bus(input logic [2:0] m,
                                               input logic [i2cm_pkg::BYTE_W-1:0] wd,
                                               input logic a, input logic s);
        line_view_t v;
        logic go;
        logic fin;
        go = 1'b0;
        fin = 1'b0;
        if (eng_kind == i2cm_pkg::KIND_IDLE)
        begin
            if (m >= i2cm_pkg::KIND_START && m <= i2cm_pkg::KIND_READ)
            begin
                eng_kind = i2cm_pkg::kind_t'(m);
                eng_seg = i2cm_pkg::PH_FIRST;
                eng_bits = '0;
                eng_shift = (m == i2cm_pkg::KIND_WRITE) ? wd : '0;
                eng_ack_out = a;
                go = 1'b1;
            end
        end
        else
        begin
            eng_wait = eng_wait - 16'd1;
            go = (eng_wait == '0);
        end
        if (go)
        begin
            fin = bus_segment(s);
            if (fin)
            begin
                eng_kind = i2cm_pkg::KIND_IDLE;
                eng_seg = i2cm_pkg::PH_FIRST;
                eng_wait = '0;
            end
        end
        v.scl = eng_scl;
        v.sda = eng_sda;
        v.busy = (eng_kind != i2cm_pkg::KIND_IDLE);
        v.done = fin;
        v.rbyte = eng_rbyte;
        v.ack = eng_ack_in;
        return v;
    endfunction

    // slave side of the bus: read data bits, then the ack level, with optional glitches
    function automatic logic slave_line(input logic [i2cm_pkg::BYTE_W-1:0] sb, input logic sa,
                                        input logic noisy);
        if (noisy && $urandom_range(0, 7) == 0)
            return 1'($urandom_range(0, 1));
        if (eng_kind == i2cm_pkg::KIND_READ && eng_bits < i2cm_pkg::BITS_PER_BYTE)
            return sb[i2cm_pkg::BYTE_W - 1 - eng_bits];
        return sa;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at beat %0d: %s", beats_seen, what);
        mismatches++;
    endtask

    task automatic cmp_field(input string nm, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", nm, got, want));
    endtask

    task automatic send_tick(input logic [2:0] m, input logic [i2cm_pkg::BYTE_W-1:0] wd,
                             input logic a, input logic s, input logic typed,
                             input line_view_t want);
        int gap;
        line_view_t got;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        write_data <= wd;
        ack_to_send <= a;
        sda_in <= s;
        do @(posedge clk); while (!in_ready);
        got = advance_bus(m, wd, a, s);
        line_views_due.push_back(typed ? want : got);
        if (got.busy || got.done)
            busy_ticks++;
    endtask

    // issues a command, then ticks until the engine is idle again
    task automatic run_cmd(input logic [2:0] m, input logic [i2cm_pkg::BYTE_W-1:0] wd,
                           input logic a, input logic [i2cm_pkg::BYTE_W-1:0] sb,
                           input logic sa, input logic noisy,
                           input logic typed, input line_view_t want);
        send_tick(m, wd, a, slave_line(sb, sa, noisy), typed, want);
        while (eng_kind != i2cm_pkg::KIND_IDLE)
        begin
            if (noisy)
                send_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                          slave_line(sb, sa, noisy), 1'b0, '0);
            else
                send_tick(m, wd, a, slave_line(sb, sa, noisy), 1'b0, '0);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (line_views_due.size() != 0);
    endtask

    task automatic set_delay(input logic [i2cm_pkg::DELAY_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        eng_delay = v;
    endtask

    initial
    begin
        dir_rows[0]  = '{1'b0, 16'd0, i2cm_pkg::KIND_IDLE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1,
                         IDLE_VIEW};
        dir_rows[1]  = '{1'b0, 16'd0, MODE_SPARE_LO, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b1, IDLE_VIEW};
        dir_rows[2]  = '{1'b0, 16'd0, MODE_SPARE_MID, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, IDLE_VIEW};
        dir_rows[3]  = '{1'b0, 16'd0, MODE_SPARE_HI, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b1, IDLE_VIEW};
        dir_rows[4]  = '{1'b1, 16'd1, i2cm_pkg::KIND_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1,
                         START_VIEW};
        dir_rows[5]  = '{1'b0, 16'd0, i2cm_pkg::KIND_WRITE, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0,
                         IDLE_VIEW};
        dir_rows[6]  = '{1'b0, 16'd0, i2cm_pkg::KIND_WRITE, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0,
                         IDLE_VIEW};
        dir_rows[7]  = '{1'b0, 16'd0, i2cm_pkg::KIND_WRITE, 8'hA5, 1'b0, 8'h00, 1'b0, 1'b0,
                         IDLE_VIEW};
        dir_rows[8]  = '{1'b0, 16'd0, i2cm_pkg::KIND_READ, 8'h00, 1'b1, 8'hFF, 1'b1, 1'b0,
                         IDLE_VIEW};
        dir_rows[9]  = '{1'b0, 16'd0, i2cm_pkg::KIND_READ, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0,
                         IDLE_VIEW};
        dir_rows[10] = '{1'b0, 16'd0, i2cm_pkg::KIND_READ, 8'h3C, 1'b1, 8'h5A, 1'b0, 1'b0,
                         IDLE_VIEW};
        dir_rows[11] = '{1'b0, 16'd0, i2cm_pkg::KIND_STOP, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0,
                         IDLE_VIEW};
        dir_rows[12] = '{1'b1, 16'd0, i2cm_pkg::KIND_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0,
                         IDLE_VIEW};
        dir_rows[13] = '{1'b0, 16'd0, i2cm_pkg::KIND_WRITE, 8'h80, 1'b0, 8'h00, 1'b1, 1'b0,
                         IDLE_VIEW};
        dir_rows[14] = '{1'b0, 16'd0, i2cm_pkg::KIND_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0,
                         IDLE_VIEW};
        dir_rows[15] = '{1'b1, 16'd3, i2cm_pkg::KIND_STOP, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0,
                         IDLE_VIEW};
        dir_rows[16] = '{1'b0, 16'd0, i2cm_pkg::KIND_READ, 8'h00, 1'b0, 8'h81, 1'b1, 1'b0,
                         IDLE_VIEW};
        dir_rows[17] = '{1'b0, 16'd0, i2cm_pkg::KIND_WRITE, 8'h7E, 1'b1, 8'h00, 1'b0, 1'b0,
                         IDLE_VIEW};
    end

    // receiver: random stalls per beat, plus long hold-offs on request
    initial
    begin
        int gap;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_asks != holds_done)
            begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                gap = calm ? 0 : $urandom_range(0, 3);
                if (gap != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        line_view_t due;
        if (rst_n && out_valid && out_ready)
        begin
            beats_seen++;
            if (line_views_due.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                due = line_views_due.pop_front();
                cmp_field("scl_release", scl_release, due.scl);
                cmp_field("sda_release", sda_release, due.sda);
                cmp_field("busy_res", busy_res, due.busy);
                cmp_field("done_res", done_res, due.done);
                cmp_field("read_data", read_data, due.rbyte);
                cmp_field("ack_seen", ack_seen, due.ack);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles", stall_cycles);
            $display("== FAIL ==");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int txn;
        logic [i2cm_pkg::BYTE_W-1:0] sb;
        in_valid = 1'b0;
        mode = i2cm_pkg::KIND_IDLE;
        write_data = '0;
        ack_to_send = 1'b0;
        sda_in = 1'b1;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].set_cfg)
                set_delay(dir_rows[r].dly);
            run_cmd(dir_rows[r].m, dir_rows[r].wd, dir_rows[r].a, dir_rows[r].sb,
                    dir_rows[r].sa, 1'b0, dir_rows[r].typed, dir_rows[r].want);
        end

        // long delay, then a shorter one set while the engine is still waiting it out
        set_delay(16'd40);
        calm = 1'b1;
        send_tick(i2cm_pkg::KIND_STOP, 8'h00, 1'b0, 1'b1, 1'b0, '0);
        repeat (4) send_tick(i2cm_pkg::KIND_IDLE, 8'h00, 1'b0, 1'b1, 1'b0, '0);
        set_delay(16'd2);
        while (eng_kind != i2cm_pkg::KIND_IDLE)
            send_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                      1'($urandom), 1'b0, '0);

        busy_ticks = 0;
        txn = 0;
        while (busy_ticks < RANDOM_TICKS)
        begin
            if (txn % 6 == 0)
                set_delay(($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 3)));
            else if (txn % 6 == 3)
                drain();
            calm = (txn == 0) || ($urandom_range(0, 3) == 0);
            if (txn == 0)
                hold_asks++;
            if ($urandom_range(0, 4) == 0)
            begin
                // noise: a lone command of any mode, out of sequence
                run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 8'($urandom),
                        1'($urandom), 1'b1, 1'b0, '0);
            end
            else
            begin
                repeat ($urandom_range(0, 2))
                    send_tick(i2cm_pkg::KIND_IDLE, 8'($urandom), 1'($urandom), 1'($urandom),
                              1'b0, '0);
                run_cmd(i2cm_pkg::KIND_START, 8'($urandom), 1'($urandom), 8'h00, 1'b1, 1'b1,
                        1'b0, '0);
                run_cmd(i2cm_pkg::KIND_WRITE, 8'($urandom), 1'($urandom), 8'h00,
                        1'($urandom), 1'b1, 1'b0, '0);
                repeat ($urandom_range(0, 3))
                begin
                    sb = 8'($urandom);
                    run_cmd(($urandom_range(0, 1) == 0) ? i2cm_pkg::KIND_READ
                                                        : i2cm_pkg::KIND_WRITE,
                            8'($urandom), 1'($urandom), sb, 1'($urandom), 1'b1, 1'b0, '0);
                end
                run_cmd(i2cm_pkg::KIND_STOP, 8'($urandom), 1'($urandom), 8'h00, 1'b1, 1'b1,
                        1'b0, '0);
            end
            txn++;
        end

        calm = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_step.sv
rtl/core/i2c_master_byte_engine.sv
bench/i2c_master_byte_engine_tb.sv
